>>> hdl/ldsi_pkg.sv
package ldsi_pkg;

    // interval arithmetic
    localparam int NS_BITS_DEF = 63;
    localparam int OUT_NS_W    = 63;
    localparam int BASE_BITS   = 30;
    localparam logic [BASE_BITS-1:0] ONE_SECOND_NS = 30'd1000000000;

    localparam int LOG_W  = 8;
    localparam int NUM_CH = 3;

    localparam logic signed [LOG_W-1:0] LOG_KEEP    = -8'sd128;
    localparam logic signed [LOG_W-1:0] LOG_INITIAL = 8'sd126;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PDELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SYNC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ANNOUNCE = 2'd2;

    // machine state codes as shown on the result
    localparam int FSM_W = 2;
    localparam logic [FSM_W-1:0] FSM_NOT_ENABLED   = 2'd0;
    localparam logic [FSM_W-1:0] FSM_INITIALIZING  = 2'd1;
    localparam logic [FSM_W-1:0] FSM_SET_INTERVALS = 2'd2;

    // request word layout
    localparam int IN_W          = 32;
    localparam int IN_BEGIN      = 0;
    localparam int IN_PORT_ON    = 1;
    localparam int IN_PTT_ON     = 2;
    localparam int IN_MSG_VALID  = 3;
    localparam int IN_LOG_LO     = 4;
    localparam int IN_RATE_RATIO = IN_LOG_LO + NUM_CH * LOG_W;
    localparam int IN_PROP_DELAY = IN_RATE_RATIO + 1;

    // result word layout
    localparam int OUT_FSM_LO     = 0;
    localparam int OUT_LOG_LO     = OUT_FSM_LO + FSM_W;
    localparam int OUT_NS_LO      = OUT_LOG_LO + NUM_CH * LOG_W;
    localparam int OUT_RATE_RATIO = OUT_NS_LO + NUM_CH * OUT_NS_W;
    localparam int OUT_PROP_DELAY = OUT_RATE_RATIO + 1;
    localparam int OUT_USED       = OUT_PROP_DELAY + 1;
    localparam int OUT_W          = ((OUT_USED + 7) / 8) * 8;
    localparam int OUT_PAD        = OUT_W - OUT_USED;

endpackage

>>> hdl/link_delay_sync_interval_setting.sv
// Interval setting machine for link delay, sync and announce timing.
// Slave channel: one request per evaluation step (begin, port enables, and
// an optional signalling message with three requested log intervals and
// the two compute flags). Master channel: one result per request, holding
// the machine state, the three current logs, the three intervals in ns
// (saturated to NS_BITS bits) and the two compute flags.
// Configuration: i_cfg_we writes the initial log selected by i_cfg_idx
// (0 peer delay, 1 sync, 2 announce); write only while the block is idle.
// A request is held in the request register, then the state update loads the
// machine registers, which are the result. One request is taken each cycle
// while the output is not stalled; the log-to-ns barrel shifts sit between the
// two registers. When the receiver stalls, the result holds and one more
// request is taken into the request register; ready drops once both are
// full. Reset empties both stages, puts the machine in not enabled, sets
// the logs and the initial values to zero and each interval to one second.
module link_delay_sync_interval_setting #(
    parameter int NS_BITS = ldsi_pkg::NS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ldsi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ldsi_pkg::LOG_W-1:0]         i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // begin_flag, port_on, ptt_port_on, msg_valid, msg_log_link_delay,
    // msg_log_sync, msg_log_announce, msg_rate_ratio, msg_prop_delay, zero pad
    input  logic [ldsi_pkg::IN_W-1:0]          i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // fsm_code, log_pdelay_now, log_sync_now, log_announce_now, pdelay_ns,
    // sync_ns, announce_ns, rate_ratio_on, prop_delay_on, zero pad
    output logic [ldsi_pkg::OUT_W-1:0]         o_m_axis_tdata
);

    typedef enum logic [ldsi_pkg::FSM_W-1:0] {
        ST_NOT_ENABLED   = ldsi_pkg::FSM_NOT_ENABLED,
        ST_INITIALIZING  = ldsi_pkg::FSM_INITIALIZING,
        ST_SET_INTERVALS = ldsi_pkg::FSM_SET_INTERVALS
    } t_state;

    typedef logic signed [ldsi_pkg::LOG_W-1:0] t_log;
    typedef logic [NS_BITS-1:0]                t_ns;

    localparam int NCH = ldsi_pkg::NUM_CH;

    logic                      r_in_valid;
    logic [ldsi_pkg::IN_W-1:0] r_in_data;
    logic                      r_out_valid;
    logic                      out_load;

    t_state r_state, n_state;
    t_log   r_init [NCH];
    t_log   r_cur  [NCH];
    t_log   n_cur  [NCH];
    t_ns    r_ns   [NCH];
    t_ns    n_ns   [NCH];
    logic   r_rate_ratio, n_rate_ratio;
    logic   r_prop_delay, n_prop_delay;

    t_log req     [NCH];
    t_log conv_in [NCH];
    t_ns  conv_ns [NCH];
    logic [ldsi_pkg::OUT_NS_W-1:0] ns_out [NCH];

    logic in_begin, in_port_on, in_ptt_on, in_msg_valid, enabled_st;

    // handshake
    assign out_load        = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCH; k++) begin
                r_init[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ldsi_pkg::CFG_INIT_PDELAY:   r_init[0] <= i_cfg_data;
                ldsi_pkg::CFG_INIT_SYNC:     r_init[1] <= i_cfg_data;
                ldsi_pkg::CFG_INIT_ANNOUNCE: r_init[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request fields
    assign in_begin     = r_in_data[ldsi_pkg::IN_BEGIN];
    assign in_port_on   = r_in_data[ldsi_pkg::IN_PORT_ON];
    assign in_ptt_on    = r_in_data[ldsi_pkg::IN_PTT_ON];
    assign in_msg_valid = r_in_data[ldsi_pkg::IN_MSG_VALID];
    assign enabled_st   = (r_state == ST_INITIALIZING) || (r_state == ST_SET_INTERVALS);

    for (genvar g = 0; g < NCH; g++) begin : g_ch
        assign req[g] = r_in_data[ldsi_pkg::IN_LOG_LO + g*ldsi_pkg::LOG_W +: ldsi_pkg::LOG_W];
        // the initial log feeds the shifter when enabling or on a restore request
        assign conv_in[g] = (!enabled_st || req[g] == ldsi_pkg::LOG_INITIAL) ?
                            r_init[g] : req[g];

        ldsi_log2ns #(
            .NS_BITS (NS_BITS)
        ) u_log2ns (
            .i_log (conv_in[g]),
            .o_ns  (conv_ns[g])
        );

        assign ns_out[g] = ldsi_pkg::OUT_NS_W'(r_ns[g]);
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_ns         = r_ns;
        n_rate_ratio = r_rate_ratio;
        n_prop_delay = r_prop_delay;
        if (in_begin || !in_port_on || !in_ptt_on) begin
            n_state = ST_NOT_ENABLED;
        end else begin
            unique case (r_state)
                ST_INITIALIZING, ST_SET_INTERVALS: begin
                    if (in_msg_valid) begin
                        for (int k = 0; k < NCH; k++) begin
                            if (req[k] != ldsi_pkg::LOG_KEEP) begin
                                n_cur[k] = conv_in[k];
                                n_ns[k]  = conv_ns[k];
                            end
                        end
                        n_rate_ratio = r_in_data[ldsi_pkg::IN_RATE_RATIO];
                        n_prop_delay = r_in_data[ldsi_pkg::IN_PROP_DELAY];
                        n_state      = ST_SET_INTERVALS;
                    end
                end
                default: begin
                    // enable: announce is left as it stands
                    n_cur[0]     = conv_in[0];
                    n_ns[0]      = conv_ns[0];
                    n_cur[1]     = conv_in[1];
                    n_ns[1]      = conv_ns[1];
                    n_rate_ratio = 1'b1;
                    n_prop_delay = 1'b1;
                    n_state      = ST_INITIALIZING;
                end
            endcase
        end
    end

    // machine state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_NOT_ENABLED;
            r_rate_ratio <= 1'b0;
            r_prop_delay <= 1'b0;
            for (int k = 0; k < NCH; k++) begin
                r_cur[k] <= '0;
                r_ns[k]  <= NS_BITS'(ldsi_pkg::ONE_SECOND_NS);
            end
        end else if (out_load) begin
            r_state      <= n_state;
            r_rate_ratio <= n_rate_ratio;
            r_prop_delay <= n_prop_delay;
            r_cur        <= n_cur;
            r_ns         <= n_ns;
        end
    end

    assign o_m_axis_tdata = {
        {ldsi_pkg::OUT_PAD{1'b0}},
        r_prop_delay,
        r_rate_ratio,
        ns_out[2], ns_out[1], ns_out[0],
        r_cur[2], r_cur[1], r_cur[0],
        r_state
    };

endmodule

>>> hdl/ldsi_log2ns.sv
module ldsi_log2ns #(
    parameter int NS_BITS = ldsi_pkg::NS_BITS_DEF
) (
    input  logic signed [ldsi_pkg::LOG_W-1:0] i_log,
    output logic        [NS_BITS-1:0]          o_ns
);

    // largest left shift that still fits, smallest right shift that leaves nothing
    localparam logic signed [ldsi_pkg::LOG_W-1:0] MAX_SHL =
        ldsi_pkg::LOG_W'(NS_BITS - ldsi_pkg::BASE_BITS);
    localparam logic signed [ldsi_pkg::LOG_W-1:0] MIN_SHR =
        ldsi_pkg::LOG_W'(-ldsi_pkg::BASE_BITS);

    logic [4:0]                     shr_amt;
    logic [NS_BITS-1:0]             base_ext;
    logic [NS_BITS-1:0]             shl_val;
    logic [ldsi_pkg::BASE_BITS-1:0] shr_val;

    always_comb begin
        shr_amt  = 5'(-i_log);
        base_ext = NS_BITS'(ldsi_pkg::ONE_SECOND_NS);
        shl_val  = base_ext << i_log[5:0];
        shr_val  = ldsi_pkg::ONE_SECOND_NS >> shr_amt;
        if (i_log[ldsi_pkg::LOG_W-1]) begin
            o_ns = (i_log <= MIN_SHR) ? '0 : NS_BITS'(shr_val);
        end else if (i_log > MAX_SHL) begin
            // saturate
            o_ns = '1;
        end else begin
            o_ns = shl_val;
        end
    end

endmodule

>>> hdl/ldsi_chk.sv
module ldsi_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [ldsi_pkg::OUT_W-1:0]     o_m_axis_tdata
);

    logic [ldsi_pkg::FSM_W-1:0] fsm_code;

    assign fsm_code = o_m_axis_tdata[ldsi_pkg::OUT_FSM_LO +: ldsi_pkg::FSM_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // with no result pending there is always room for a request
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("request refused with empty output");

    // entering initializing sets both flags and only a message changes them, which also leaves it
    a_init_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && fsm_code == ldsi_pkg::FSM_INITIALIZING |->
            o_m_axis_tdata[ldsi_pkg::OUT_RATE_RATIO] && o_m_axis_tdata[ldsi_pkg::OUT_PROP_DELAY])
        else $error("compute flag clear while initializing");

    // reset empties the output and returns to not enabled
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && fsm_code == ldsi_pkg::FSM_NOT_ENABLED)
        else $error("state after reset wrong");

endmodule

bind link_delay_sync_interval_setting ldsi_chk u_ldsi_chk (.*);

>>> sim/tb.sv
module tb;

    // request word, lowest bit first: restart, port_on, ptt_on, msg_valid,
    // log_pdelay, log_sync, log_announce, rate_ratio, prop_delay, pad
    typedef struct packed {
        logic [ldsi_pkg::IN_W-ldsi_pkg::IN_PROP_DELAY-2:0] pad;
        logic                                              prop_delay;
        logic                                              rate_ratio;
        logic [ldsi_pkg::LOG_W-1:0]                        log_announce;
        logic [ldsi_pkg::LOG_W-1:0]                        log_sync;
        logic [ldsi_pkg::LOG_W-1:0]                        log_pdelay;
        logic                                              msg_valid;
        logic                                              ptt_on;
        logic                                              port_on;
        logic                                              restart;
    } t_request;

    typedef struct packed {
        logic [ldsi_pkg::OUT_PAD-1:0]  pad;
        logic                          prop_delay_on;
        logic                          rate_ratio_on;
        logic [ldsi_pkg::OUT_NS_W-1:0] announce_ns;
        logic [ldsi_pkg::OUT_NS_W-1:0] sync_ns;
        logic [ldsi_pkg::OUT_NS_W-1:0] pdelay_ns;
        logic [ldsi_pkg::LOG_W-1:0]    log_announce;
        logic [ldsi_pkg::LOG_W-1:0]    log_sync;
        logic [ldsi_pkg::LOG_W-1:0]    log_pdelay;
        logic [ldsi_pkg::FSM_W-1:0]    fsm_code;
    } t_status;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ldsi_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [ldsi_pkg::LOG_W-1:0]     i_cfg_data;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [ldsi_pkg::IN_W-1:0]      i_s_axis_tdata;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [ldsi_pkg::OUT_W-1:0]     o_m_axis_tdata;

    link_delay_sync_interval_setting u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // machine copy: channel 0 peer delay, 1 sync, 2 announce
    logic [ldsi_pkg::FSM_W-1:0] mdl_fsm;
    logic [ldsi_pkg::LOG_W-1:0] mdl_init_log [ldsi_pkg::NUM_CH];
    logic [ldsi_pkg::LOG_W-1:0] mdl_cur_log  [ldsi_pkg::NUM_CH];
    logic [63:0]                mdl_ns       [ldsi_pkg::NUM_CH];
    logic                       mdl_rate_ratio;
    logic                       mdl_prop_delay;

    t_status pending_status [$];
    int      mismatch_count;
    int      status_count;
    logic    throttle;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("[link_delay_sync_interval_setting] ERROR");
        $finish;
    end

    // 10^9 * 2^lg ns: right shifts truncate, left shifts saturate at 2^63-1
    function automatic logic [63:0] interval_ns(
        input logic signed [ldsi_pkg::LOG_W-1:0] lg);
        logic [63:0] base;
        logic [63:0] ns_max;
        int          l;
        base   = 64'(ldsi_pkg::ONE_SECOND_NS);
        ns_max = 64'h7FFF_FFFF_FFFF_FFFF;
        l      = int'(lg);
        if (l < 0) return (-l >= 64) ? 64'd0 : (base >> (-l));
        if (l >= 64 || base > (ns_max >> l)) return ns_max;
        return base << l;
    endfunction

    task automatic reset_machine();
        mdl_fsm        = ldsi_pkg::FSM_NOT_ENABLED;
        mdl_rate_ratio = 1'b0;
        mdl_prop_delay = 1'b0;
        for (int ch = 0; ch < ldsi_pkg::NUM_CH; ch++) begin
            mdl_init_log[ch] = '0;
            mdl_cur_log[ch]  = '0;
            mdl_ns[ch]       = 64'(ldsi_pkg::ONE_SECOND_NS);
        end
    endtask

    task automatic advance_machine(input t_request rq);
        logic [ldsi_pkg::LOG_W-1:0] req_log [ldsi_pkg::NUM_CH];
        t_status                    st;
        req_log[0] = rq.log_pdelay;
        req_log[1] = rq.log_sync;
        req_log[2] = rq.log_announce;
        if (rq.restart || !rq.port_on || !rq.ptt_on) begin
            mdl_fsm = ldsi_pkg::FSM_NOT_ENABLED;
        end else if (mdl_fsm == ldsi_pkg::FSM_INITIALIZING ||
                     mdl_fsm == ldsi_pkg::FSM_SET_INTERVALS) begin
            if (rq.msg_valid) begin
                for (int ch = 0; ch < ldsi_pkg::NUM_CH; ch++) begin
                    if (req_log[ch] == ldsi_pkg::LOG_INITIAL) begin
                        mdl_cur_log[ch] = mdl_init_log[ch];
                        mdl_ns[ch]      = interval_ns(mdl_init_log[ch]);
                    end else if (req_log[ch] != ldsi_pkg::LOG_KEEP) begin
                        mdl_cur_log[ch] = req_log[ch];
                        mdl_ns[ch]      = interval_ns(req_log[ch]);
                    end
                end
                mdl_rate_ratio = rq.rate_ratio;
                mdl_prop_delay = rq.prop_delay;
                mdl_fsm        = ldsi_pkg::FSM_SET_INTERVALS;
            end
        end else begin
            // announce is left alone on enabling
            for (int ch = 0; ch < 2; ch++) begin
                mdl_cur_log[ch] = mdl_init_log[ch];
                mdl_ns[ch]      = interval_ns(mdl_init_log[ch]);
            end
            mdl_rate_ratio = 1'b1;
            mdl_prop_delay = 1'b1;
            mdl_fsm        = ldsi_pkg::FSM_INITIALIZING;
        end
        st               = '0;
        st.fsm_code      = mdl_fsm;
        st.log_pdelay    = mdl_cur_log[0];
        st.log_sync      = mdl_cur_log[1];
        st.log_announce  = mdl_cur_log[2];
        st.pdelay_ns     = mdl_ns[0][ldsi_pkg::OUT_NS_W-1:0];
        st.sync_ns       = mdl_ns[1][ldsi_pkg::OUT_NS_W-1:0];
        st.announce_ns   = mdl_ns[2][ldsi_pkg::OUT_NS_W-1:0];
        st.rate_ratio_on = mdl_rate_ratio;
        st.prop_delay_on = mdl_prop_delay;
        pending_status.push_back(st);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on %s in result %0d: got %0h, want %0h",
                     field, status_count, got, want);
    endtask

    always @(negedge i_clk) begin
        i_m_axis_tready <= !throttle || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_status'(o_m_axis_tdata);
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected result", got[63:0], 64'd0);
            end else begin
                want = pending_status.pop_front();
                if (got.fsm_code !== want.fsm_code)
                    report_mismatch("fsm_code", 64'(got.fsm_code), 64'(want.fsm_code));
                if (got.log_pdelay !== want.log_pdelay)
                    report_mismatch("log_pdelay_now", 64'(got.log_pdelay), 64'(want.log_pdelay));
                if (got.log_sync !== want.log_sync)
                    report_mismatch("log_sync_now", 64'(got.log_sync), 64'(want.log_sync));
                if (got.log_announce !== want.log_announce)
                    report_mismatch("log_announce_now", 64'(got.log_announce),
                                    64'(want.log_announce));
                if (got.pdelay_ns !== want.pdelay_ns)
                    report_mismatch("pdelay_ns", 64'(got.pdelay_ns), 64'(want.pdelay_ns));
                if (got.sync_ns !== want.sync_ns)
                    report_mismatch("sync_ns", 64'(got.sync_ns), 64'(want.sync_ns));
                if (got.announce_ns !== want.announce_ns)
                    report_mismatch("announce_ns", 64'(got.announce_ns), 64'(want.announce_ns));
                if (got.rate_ratio_on !== want.rate_ratio_on)
                    report_mismatch("rate_ratio_on", 64'(got.rate_ratio_on),
                                    64'(want.rate_ratio_on));
                if (got.prop_delay_on !== want.prop_delay_on)
                    report_mismatch("prop_delay_on", 64'(got.prop_delay_on),
                                    64'(want.prop_delay_on));
            end
            status_count++;
        end
    end

    task automatic send_request(input t_request rq);
        @(negedge i_clk);
        while (throttle && $urandom_range(99) < 11) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rq;
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_machine(rq);
    endtask

    // hold off until every result is in and the pipeline has emptied
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_init_logs(input logic [ldsi_pkg::LOG_W-1:0] pd,
                                     input logic [ldsi_pkg::LOG_W-1:0] sy,
                                     input logic [ldsi_pkg::LOG_W-1:0] an);
        logic [ldsi_pkg::LOG_W-1:0]     vals [ldsi_pkg::NUM_CH];
        logic [ldsi_pkg::CFG_IDX_W-1:0] idx  [ldsi_pkg::NUM_CH];
        vals = '{pd, sy, an};
        idx  = '{ldsi_pkg::CFG_INIT_PDELAY, ldsi_pkg::CFG_INIT_SYNC,
                 ldsi_pkg::CFG_INIT_ANNOUNCE};
        for (int ch = 0; ch < ldsi_pkg::NUM_CH; ch++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[ch];
            i_cfg_data <= vals[ch];
            @(posedge i_clk);
            mdl_init_log[ch] = vals[ch];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_request make_request(input logic en, input logic msg,
                                              input logic [ldsi_pkg::LOG_W-1:0] pd,
                                              input logic [ldsi_pkg::LOG_W-1:0] sy,
                                              input logic [ldsi_pkg::LOG_W-1:0] an,
                                              input logic rr, input logic prop);
        t_request rq;
        rq              = '0;
        rq.port_on      = en;
        rq.ptt_on       = en;
        rq.msg_valid    = msg;
        rq.log_pdelay   = pd;
        rq.log_sync     = sy;
        rq.log_announce = an;
        rq.rate_ratio   = rr;
        rq.prop_delay   = prop;
        return rq;
    endfunction

    // favour keep, restore and the shift boundaries
    function automatic logic [ldsi_pkg::LOG_W-1:0] pick_log();
        case ($urandom_range(9))
            0, 1:    return ldsi_pkg::LOG_KEEP;
            2:       return ldsi_pkg::LOG_INITIAL;
            3:       return 8'(int'($urandom_range(64)) - 32);
            4:       return 8'($urandom_range(120, 127));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_request random_message();
        return make_request(1'b1, 1'b1, pick_log(), pick_log(), pick_log(),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic test_disabled_hold();
        t_request rq;
        send_request(make_request(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
        rq = make_request(1'b1, 1'b1, 8'd5, 8'd5, 8'd5, 1'b1, 1'b1);
        rq.ptt_on = 1'b0;
        send_request(rq);
        rq = make_request(1'b1, 1'b1, 8'd7, 8'd7, 8'd7, 1'b1, 1'b0);
        rq.port_on = 1'b0;
        send_request(rq);
        rq = make_request(1'b1, 1'b1, 8'd9, 8'd9, 8'd9, 1'b0, 1'b1);
        rq.restart = 1'b1;
        send_request(rq);
    endtask

    task automatic test_enable_and_messages();
        t_request rq;
        drain();
        program_init_logs(8'sd3, -8'sd2, 8'sd5);
        // message in the enabling step is dropped
        send_request(make_request(1'b1, 1'b1, 8'sd10, 8'sd10, 8'sd10, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b1, ldsi_pkg::LOG_KEEP, ldsi_pkg::LOG_KEEP,
                                  ldsi_pkg::LOG_KEEP, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b1, ldsi_pkg::LOG_INITIAL, ldsi_pkg::LOG_INITIAL,
                                  ldsi_pkg::LOG_INITIAL, 1'b1, 1'b0));
        send_request(make_request(1'b1, 1'b1, 8'sd127, ldsi_pkg::LOG_KEEP, -8'sd127,
                                  1'b0, 1'b1));
        send_request(make_request(1'b1, 1'b1, 8'sd33, 8'sd34, -8'sd29, 1'b1, 1'b1));
        send_request(make_request(1'b1, 1'b1, -8'sd30, 8'sd0, 8'sd125, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b1, -8'sd1, 8'sd1, -8'sd64, 1'b1, 1'b0));
        send_request(make_request(1'b1, 1'b0, 8'sd2, 8'sd2, 8'sd2, 1'b0, 1'b1));
        rq = make_request(1'b1, 1'b1, 8'sd4, 8'sd4, 8'sd4, 1'b0, 1'b0);
        rq.restart = 1'b1;
        send_request(rq);
        send_request(make_request(1'b0, 1'b1, 8'sd6, 8'sd6, 8'sd6, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        send_request(make_request(1'b1, 1'b1, 8'h7E, 8'h81, 8'h00, 1'b0, 1'b1));
    endtask

    task automatic test_init_extremes();
        drain();
        program_init_logs(8'sd127, ldsi_pkg::LOG_KEEP, ldsi_pkg::LOG_INITIAL);
        send_request(make_request(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b1, ldsi_pkg::LOG_INITIAL, ldsi_pkg::LOG_INITIAL,
                                  ldsi_pkg::LOG_INITIAL, 1'b0, 1'b0));
        drain();
        program_init_logs(ldsi_pkg::LOG_KEEP, 8'sd127, -8'sd31);
        send_request(make_request(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0));
        send_request(make_request(1'b1, 1'b1, ldsi_pkg::LOG_INITIAL, ldsi_pkg::LOG_INITIAL,
                                  ldsi_pkg::LOG_INITIAL, 1'b1, 1'b1));
    endtask

    // enable, a run of messages with noise mixed in, then a drop out
    task automatic run_sessions(input int items);
        t_request rq;
        int       sent;
        sent = 0;
        while (sent < items) begin
            rq = random_message();
            rq.msg_valid = 1'($urandom_range(1));
            send_request(rq);
            sent++;
            repeat ($urandom_range(4, 40)) begin
                if ($urandom_range(99) < 12) begin
                    rq = t_request'(ldsi_pkg::IN_W'($urandom_range(32'h3FFF_FFFF)));
                end else begin
                    rq = random_message();
                    rq.msg_valid = ($urandom_range(9) != 0);
                end
                send_request(rq);
                sent++;
            end
            rq = random_message();
            case ($urandom_range(2))
                0:       rq.restart = 1'b1;
                1:       rq.port_on = 1'b0;
                default: rq.ptt_on  = 1'b0;
            endcase
            send_request(rq);
            sent++;
        end
    endtask

    task automatic test_random();
        drain();
        program_init_logs(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        run_sessions(450);
        // no idling on either side for this stretch
        throttle = 1'b0;
        drain();
        program_init_logs(8'(int'($urandom_range(64)) - 32), 8'(int'($urandom_range(64)) - 32),
                          8'(int'($urandom_range(64)) - 32));
        run_sessions(450);
        throttle = 1'b1;
        drain();
        program_init_logs(8'sd126, 8'sd0, ldsi_pkg::LOG_KEEP);
        run_sessions(450);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        throttle        = 1'b1;
        mismatch_count  = 0;
        status_count    = 0;
        reset_machine();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_hold();
        test_enable_and_messages();
        test_init_extremes();
        test_random();

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("[link_delay_sync_interval_setting] OK");
        end else begin
            $display("[link_delay_sync_interval_setting] ERROR");
        end
        $finish;
    end
endmodule
